// File: sv/iimt_pkg.sv
// Shared types and constants for the interval insert/merge table.
`timescale 1ns / 1ps
`default_nettype none
package iimt_pkg;

	localparam int unsigned DEPTH_DEFAULT = 32;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_ORDER = 2'd2;

	typedef struct packed {
		logic signed [31:0] hi;
		logic signed [31:0] lo;
	} span_t;

	typedef struct packed {
		logic  shift;
		logic  wr;
		span_t wdata;
	} cell_ctl_t;

endpackage
`default_nettype wire

// File: sv/iimt_cell.sv
// One table cell: holds an interval, takes its right neighbor on shift or a written entry.
`timescale 1ns / 1ps
`default_nettype none
module iimt_cell
	import iimt_pkg::*;
#(
	parameter int unsigned IDX = 0,
	parameter int unsigned IW  = 5
) (
	input  wire logic      clk,
	input  wire cell_ctl_t ctl,
	input  wire logic [IW-1:0] widx,
	input  wire span_t     nxt,
	output span_t          q
);

	span_t span_q;

	always_ff @(posedge clk) begin
		if (ctl.wr && widx == IDX[IW-1:0]) begin
			span_q <= ctl.wdata;
		end else if (ctl.shift) begin
			span_q <= nxt;
		end
	end

	assign q = span_q;

endmodule
`default_nettype wire

// File: sv/interval_insert_merge_table_top.sv
// Top level: interval table as a chain of cells with scan, merge and emit sequencing.
`timescale 1ns / 1ps
`default_nettype none
// Sorted table of disjoint closed intervals held in a row of TABLE_DEPTH cells that shift
// toward cell 0; the entry in cell 0 is the one examined each cycle. An accepted interval
// is merged in one pass over the N stored entries. When the table is full a prior pass
// over the entries checks for overlap and rejects the interval if none is found. The
// updated table of M entries is then rotated out one entry per cycle while the output is
// not stalled, with a single all-zero last entry for an empty table. A start after end
// rejection skips both passes and emits the unchanged table. Input is taken only between
// items; the output register lets the last result wait while the next item is accepted.
module interval_insert_merge_table_top
	import iimt_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = DEPTH_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,  // new_start[31:0], new_end[63:32]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata,  // out_start[31:0], out_end[63:32]
	output logic             m_axis_tlast,
	output logic [1:0]       m_axis_tuser   // status[1:0]
);

	localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);
	localparam logic [CW-1:0] ONE  = CW'(1);

	typedef enum logic [1:0] {IDLE, CHECK, MERGE, EMIT} state_t;

	state_t        state_q;
	logic [CW-1:0] cnt_q, rem_q, occ_q;
	logic          placed_q, ovl_q;
	logic [1:0]    status_q;
	span_t         mrg_q;
	logic          ovalid_q;
	span_t         odata_q;
	logic          olast_q;
	logic [1:0]    ostat_q;

	span_t         cell_q [TABLE_DEPTH];
	span_t         head;
	cell_ctl_t     ctl;
	logic [CW-1:0] wpos;
	logic [IW-1:0] widx;
	logic          below, overlap, pop, push;
	logic          out_free;
	span_t         in_span;

	assign in_span.lo = s_axis_tdata[31:0];
	assign in_span.hi = s_axis_tdata[63:32];
	assign head       = cell_q[0];
	assign below      = head.hi < mrg_q.lo;
	assign overlap    = !below && head.lo <= mrg_q.hi;
	assign out_free   = !ovalid_q || m_axis_tready;
	assign s_axis_tready = state_q == IDLE;

	always_comb begin
		pop  = 1'b0;
		push = 1'b0;
		ctl.wdata = head;
		wpos = cnt_q - ONE;
		unique case (state_q)
			CHECK: begin
				pop  = 1'b1;
				push = 1'b1;
			end
			MERGE: begin
				wpos = occ_q;
				if (rem_q != '0) begin
					if (below) begin
						pop  = 1'b1;
						push = 1'b1;
					end else if (overlap) begin
						pop = 1'b1;
					end else if (!placed_q) begin
						push = 1'b1;
						ctl.wdata = mrg_q;
					end else begin
						pop  = 1'b1;
						push = 1'b1;
					end
					wpos = occ_q - CW'(pop);
				end else begin
					push = !placed_q;
					ctl.wdata = mrg_q;
				end
			end
			EMIT: begin
				if (out_free && cnt_q != '0) begin
					pop  = 1'b1;
					push = 1'b1;
				end
			end
			default: ;
		endcase
		ctl.shift = pop;
		ctl.wr    = push;
		widx      = wpos[IW-1:0];
	end

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		span_t nxt;
		if (g == TABLE_DEPTH - 1) begin : g_end
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = cell_q[g+1];
		end
		iimt_cell #(.IDX(g), .IW(IW)) u_cell (
			.clk (clk),
			.ctl (ctl),
			.widx(widx),
			.nxt (nxt),
			.q   (cell_q[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= IDLE;
			cnt_q    <= '0;
			rem_q    <= '0;
			occ_q    <= '0;
			placed_q <= 1'b0;
			ovl_q    <= 1'b0;
			status_q <= ST_OK;
			mrg_q    <= '0;
			ovalid_q <= 1'b0;
			odata_q  <= '0;
			olast_q  <= 1'b0;
			ostat_q  <= ST_OK;
		end else begin
			if (m_axis_tready && state_q != EMIT) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (s_axis_tvalid) begin
						mrg_q    <= in_span;
						rem_q    <= cnt_q;
						occ_q    <= cnt_q;
						placed_q <= 1'b0;
						ovl_q    <= 1'b0;
						if (in_span.lo > in_span.hi) begin
							status_q <= ST_ORDER;
							state_q  <= EMIT;
						end else if (cnt_q == FULL) begin
							state_q <= CHECK;
						end else begin
							state_q <= MERGE;
						end
					end
				end
				CHECK: begin
					ovl_q <= ovl_q || overlap;
					if (rem_q == ONE) begin
						rem_q <= cnt_q;
						if (ovl_q || overlap) begin
							state_q <= MERGE;
						end else begin
							status_q <= ST_FULL;
							state_q  <= EMIT;
						end
					end else begin
						rem_q <= rem_q - ONE;
					end
				end
				MERGE: begin
					if (rem_q != '0) begin
						if (pop) begin
							rem_q <= rem_q - ONE;
						end
						if (overlap) begin
							if (head.lo < mrg_q.lo) begin
								mrg_q.lo <= head.lo;
							end
							if (head.hi > mrg_q.hi) begin
								mrg_q.hi <= head.hi;
							end
						end
						if (push && !pop) begin
							placed_q <= 1'b1;
						end
						occ_q <= occ_q - CW'(pop) + CW'(push);
					end else begin
						cnt_q    <= occ_q + CW'(push);
						rem_q    <= occ_q + CW'(push);
						status_q <= ST_OK;
						state_q  <= EMIT;
					end
				end
				EMIT: begin
					if (out_free) begin
						ovalid_q <= 1'b1;
						ostat_q  <= status_q;
						if (cnt_q == '0) begin
							odata_q <= '0;
							olast_q <= 1'b1;
							state_q <= IDLE;
						end else begin
							odata_q <= head;
							olast_q <= rem_q == ONE;
							rem_q   <= rem_q - ONE;
							if (rem_q == ONE) begin
								state_q <= IDLE;
							end
						end
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = {odata_q.hi, odata_q.lo};
	assign m_axis_tlast  = olast_q;
	assign m_axis_tuser  = ostat_q;

endmodule
`default_nettype wire

// File: test/iimt_checker.sv
// Checker: watches both streams, predicts the emitted interval table and compares.
`timescale 1ns / 1ps
`default_nettype none
module iimt_checker
	import iimt_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = DEPTH_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [63:0] m_axis_tdata,
	input  wire logic        m_axis_tlast,
	input  wire logic [1:0]  m_axis_tuser,
	output int               fail_count,
	output int               pending
);

	typedef struct {
		logic signed [31:0] lo;
		logic signed [31:0] hi;
		logic               fin;
		logic [1:0]         status;
	} table_row_t;

	span_t      spans[TABLE_DEPTH];
	int         span_count;
	table_row_t expected_rows[$];

	assign pending = expected_rows.size();

	task automatic emit_table(input logic [1:0] status);
		table_row_t r;
		if (span_count == 0) begin
			r.lo = '0; r.hi = '0; r.fin = 1'b1; r.status = status;
			expected_rows.insert(expected_rows.size(), r);
		end else begin
			for (int k = 0; k < span_count; k++) begin
				r.lo = spans[k].lo; r.hi = spans[k].hi;
				r.fin = (k == span_count - 1); r.status = status;
				expected_rows.insert(expected_rows.size(), r);
			end
		end
	endtask

	task automatic insert_interval(input logic signed [31:0] ns_in,
			input logic signed [31:0] ne_in);
		span_t              merged_tab[TABLE_DEPTH];
		logic signed [31:0] ns;
		logic signed [31:0] ne;
		int                 i;
		int                 n;
		int                 hits;
		ns = ns_in; ne = ne_in; i = 0; n = 0; hits = 0;
		if (ns > ne) begin
			emit_table(ST_ORDER);
			return;
		end
		while (i < span_count && spans[i].hi < ns) begin
			merged_tab[n] = spans[i]; n++; i++;
		end
		while (i < span_count && spans[i].lo <= ne) begin
			if (spans[i].lo < ns) ns = spans[i].lo;
			if (spans[i].hi > ne) ne = spans[i].hi;
			hits++; i++;
		end
		if (hits == 0 && span_count >= TABLE_DEPTH) begin
			emit_table(ST_FULL);
			return;
		end
		merged_tab[n].lo = ns; merged_tab[n].hi = ne; n++;
		while (i < span_count && n < TABLE_DEPTH) begin
			merged_tab[n] = spans[i]; n++; i++;
		end
		for (int k = 0; k < n; k++) spans[k] = merged_tab[k];
		span_count = n;
		emit_table(ST_OK);
	endtask

	always @(posedge clk or negedge arst_n) begin
		table_row_t e;
		if (!arst_n) begin
			span_count = 0;
			fail_count = 0;
			expected_rows.delete();
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				insert_interval(s_axis_tdata[31:0], s_axis_tdata[63:32]);
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_rows.size() == 0) begin
					$error("unexpected result transaction %h", m_axis_tdata);
					fail_count++;
				end else begin
					e = expected_rows.pop_front();
					if (m_axis_tdata[31:0] !== e.lo) begin
						$error("out_start exp %0d got %0d", e.lo,
							$signed(m_axis_tdata[31:0]));
						fail_count++;
					end
					if (m_axis_tdata[63:32] !== e.hi) begin
						$error("out_end exp %0d got %0d", e.hi,
							$signed(m_axis_tdata[63:32]));
						fail_count++;
					end
					if (m_axis_tlast !== e.fin) begin
						$error("last exp %0d got %0d", e.fin, m_axis_tlast);
						fail_count++;
					end
					if (m_axis_tuser !== e.status) begin
						$error("status exp %0d got %0d", e.status, m_axis_tuser);
						fail_count++;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

// File: test/tb_top.sv
// Testbench top: drives intervals through the table with varied flow control.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import iimt_pkg::*;

	localparam int unsigned DEPTH = DEPTH_DEFAULT;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic [1:0]  m_axis_tuser;
	int          fail_count;
	int          pending;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          hold_off = 0;

	always #5 clk = ~clk;

	interval_insert_merge_table_top #(.TABLE_DEPTH(DEPTH)) u_dut (.*);
	iimt_checker #(.TABLE_DEPTH(DEPTH)) u_chk (.*);

	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_interval(input logic signed [31:0] lo, input logic signed [31:0] hi);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {hi, lo};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4 * DEPTH + 10) @(posedge clk);
	endtask

	task automatic random_interval(input int scale);
		logic signed [31:0] lo;
		logic signed [31:0] hi;
		int                 mode;
		mode = $urandom_range(99);
		if (mode < 6) begin
			lo = $urandom; hi = $urandom;
		end else if (mode < 12) begin
			hi = $signed($urandom_range(scale)) - scale / 2;
			lo = hi + 1 + $urandom_range(20);
		end else begin
			lo = $signed($urandom_range(scale)) - scale / 2;
			hi = lo + $urandom_range(scale / 40 + 1);
		end
		send_interval(lo, hi);
	endtask

	initial begin
		#10ms;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: reject on empty, extremes, touching, adjacency, merges
		send_interval(5, 4);
		send_interval(32'sh8000_0000, 32'sh8000_0000);
		send_interval(32'sh7fff_ffff, 32'sh7fff_ffff);
		send_interval(32'sh7fff_ffff, 32'sh8000_0000);
		send_interval(10, 20);
		send_interval(21, 30);
		send_interval(30, 40);
		send_interval(0, 5);
		send_interval(5, 10);
		send_interval(100, 200);
		send_interval(-50, -40);
		send_interval(-39, -39);
		send_interval(-60, 150);
		send_interval(32'sh8000_0000, 32'sh7fff_ffff);
		send_interval(1, 2);
		drain_results();
		// fill the table, then hit full rejection and merges while full
		for (int k = 0; k < 40; k++) send_interval(k * 10, k * 10 + 2);
		send_interval(1000, 1001);
		send_interval(3, 3);
		send_interval(5, 10);
		send_interval(-7, -9);
		drain_results();
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 51 : 18) : 0;
			recv_stall_pct = (ph == 2) ? 51 : (ph == 3) ? 18 : 0;
			if (ph == 2) hold_off = 600;
			for (int k = 0; k < 77; k++) random_interval((k % 3 == 0) ? 2000 : 400);
			drain_results();
			send_interval(32'sh8000_0000, 32'sh7fff_ffff);
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		drain_results();
		if (fail_count == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end

endmodule
`default_nettype wire

// File: files.f
sv/iimt_pkg.sv
sv/iimt_cell.sv
sv/interval_insert_merge_table_top.sv
test/iimt_checker.sv
test/tb_top.sv
